// ===== rtl/edd_pkg.sv =====
`timescale 1ns / 1ps
package edd_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int ERR_W     = 10;
  localparam int PROD_W    = ERR_W + 4;
  localparam int SUM_W     = ERR_W + 1;
  localparam int CFG_W     = 11;
  localparam int CIDX_W    = 2;
  localparam int TRIO_W    = 3 * ERR_W;

  localparam logic [CIDX_W-1:0] REG_METHOD    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FORMAT    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ROW_WIDTH = 2'd2;

  localparam logic METHOD_FS  = 1'b0;
  localparam logic METHOD_ATK = 1'b1;
  localparam logic FMT_RGB121 = 1'b0;
  localparam logic FMT_RGB332 = 1'b1;

  localparam logic [CFG_W-1:0] RESET_ROW_WIDTH = 11'd320;

  localparam logic [2:0] FS_RIGHT      = 3'd7;
  localparam logic [2:0] FS_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] FS_DOWN       = 3'd5;
  localparam logic [2:0] FS_DOWN_RIGHT = 3'd1;

  typedef logic [COL_W-1:0] col_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef err_t [2:0] trio_t;
  typedef logic [2:0][PIX_W-1:0] pix3_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] idx;
  } res_t;

  function automatic col_t last_col_of(logic [CFG_W-1:0] rw);
    col_t lc;
    if (rw == '0) begin
      lc = '0;
    end else if (int'(rw) > MAX_WIDTH) begin
      lc = col_t'(MAX_WIDTH - 1);
    end else begin
      lc = col_t'(rw - CFG_W'(1));
    end
    return lc;
  endfunction

  function automatic logic [2:0] level_of(logic [PIX_W-1:0] v, int n);
    logic [10:0] t;
    logic [2:0]  cnt;
    t   = 11'(v) * 11'(n) + 11'd127;
    cnt = '0;
    for (int k = 1; k <= 7; k++) begin
      if (k <= n && t >= 11'(255 * k)) begin
        cnt = cnt + 3'd1;
      end
    end
    return cnt;
  endfunction

  function automatic logic [PIX_W-1:0] grid7(logic [2:0] lvl);
    logic [PIX_W-1:0] g;
    case (lvl)
      3'd0:    g = 8'd0;
      3'd1:    g = 8'd36;
      3'd2:    g = 8'd72;
      3'd3:    g = 8'd109;
      3'd4:    g = 8'd145;
      3'd5:    g = 8'd182;
      3'd6:    g = 8'd218;
      default: g = 8'd255;
    endcase
    return g;
  endfunction

  function automatic logic [PIX_W-1:0] grid3(logic [1:0] lvl);
    logic [PIX_W-1:0] g;
    case (lvl)
      2'd0:    g = 8'd0;
      2'd1:    g = 8'd85;
      2'd2:    g = 8'd170;
      default: g = 8'd255;
    endcase
    return g;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_px(logic [PIX_W-1:0] p, err_t e);
    logic signed [SUM_W-1:0] s;
    logic [PIX_W-1:0]        r;
    s = $signed({3'b000, p}) + SUM_W'(e);
    if (s < 0) begin
      r = '0;
    end else if (s > $signed(SUM_W'(255))) begin
      r = '1;
    end else begin
      r = s[PIX_W-1:0];
    end
    return r;
  endfunction

  function automatic err_t err_of(logic [PIX_W-1:0] v, logic [PIX_W-1:0] g);
    return $signed({2'b00, v}) - $signed({2'b00, g});
  endfunction

  function automatic err_t fs_share(err_t e, logic [2:0] k);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] q;
    p = PROD_W'(e) * $signed({(PROD_W - 3)'(0), k});
    q = p + (p[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
    return err_t'(q >>> 4);
  endfunction

  function automatic err_t atk_share(err_t e);
    logic signed [SUM_W-1:0] q;
    q = SUM_W'(e) + (e[ERR_W-1] ? SUM_W'(7) : SUM_W'(0));
    return err_t'(q >>> 3);
  endfunction

  function automatic err_t add_err(err_t a, err_t b);
    return a + b;
  endfunction

endpackage

// ===== rtl/edd_ram.sv =====
`timescale 1ns / 1ps
module edd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/error_diffusion_dither_core.sv =====
`timescale 1ns / 1ps
// Error-diffusion dither core. RGB888 pixels arrive in raster order on the in_ stream and
// leave as RGB121 or RGB332 palette indexes on the out_ stream, one result item per input
// item, with out_tlast marking the last pixel of each row.
// The cfg_ port writes the diffusion method, the output format and the row width. Any write
// to a known register restarts the image: column zero, no carried error.
// Throughput is one item per clock while the skid register is empty. The error carried
// from a pixel to its right neighbor loops through clamp, quantize and weight back into a
// register, and the row store is a single-port-write RAM that takes the finished next-row
// error of column x-1 with each item past column zero; each result is registered.
// The output is a result register plus a skid register, so an item is taken while a result
// waits; in_tready falls only when both hold results the receiver has not taken.
// After reset or a configuration write the first row reads zero error from a row flag, so no
// clearing pass is needed and items are accepted at once.
module error_diffusion_dither_core
  import edd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // palette_index [7:0]
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic  method_r, method_nxt;
  logic  format_r, format_nxt;
  col_t  lastcol_r, lastcol_nxt;
  col_t  col_r, col_nxt;
  logic  first_row_r, first_row_nxt;
  trio_t acc_cur_r, acc_cur_nxt;
  trio_t acc_cur2_r, acc_cur2_nxt;
  trio_t nrow_prev_r, nrow_prev_nxt;
  trio_t nrow_cur_r, nrow_cur_nxt;
  logic  pend_r, pend_nxt;
  col_t  pend_addr_r;
  trio_t pend_data_r, pend_data_nxt;
  logic  fwd_hit_r, fwd_hit_nxt;
  trio_t fwd_data_r, fwd_data_nxt;

  logic  out_valid_r, out_valid_nxt;
  res_t  out_r, out_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  res_t  skid_r, skid_nxt;

  logic  in_fire, cfg_fire, clr;
  logic  px_last, has_left, has_r2;
  trio_t prev_err, cur_err, err_c, fin_data;
  trio_t sh_r1, sh_r2, sh_dl, sh_dn, sh_dr;
  pix3_t pix_c, v_c, g_c;
  logic [2:0] lr, lg, lb;
  logic [PIX_W-1:0] idx;
  res_t  res;

  logic        wr_norm_en, wr_en;
  col_t        wr_addr;
  trio_t       wr_data;
  logic [TRIO_W-1:0] ram_rd_data;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    method_nxt  = method_r;
    format_nxt  = format_r;
    lastcol_nxt = lastcol_r;
    clr         = 1'b0;
    if (cfg_fire) begin
      case (cfg_index)
        REG_METHOD: begin
          method_nxt = cfg_data[0];
          clr        = 1'b1;
        end
        REG_FORMAT: begin
          format_nxt = cfg_data[0];
          clr        = 1'b1;
        end
        REG_ROW_WIDTH: begin
          lastcol_nxt = last_col_of(cfg_data);
          clr         = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    px_last  = (col_r == lastcol_r);
    has_left = (col_r != '0);
    has_r2   = !px_last && (col_t'(col_r + col_t'(1)) != lastcol_r);
    prev_err = first_row_r ? '0 : (fwd_hit_r ? fwd_data_r : trio_t'(ram_rd_data));

    for (int c = 0; c < 3; c++) begin
      pix_c[c]   = in_tdata[PIX_W*c +: PIX_W];
      cur_err[c] = add_err(prev_err[c], acc_cur_r[c]);
      v_c[c]     = clamp_px(pix_c[c], cur_err[c]);
    end

    lr = '0;
    lg = '0;
    lb = '0;
    if (format_r == FMT_RGB332) begin
      lr     = level_of(v_c[0], 7);
      lg     = level_of(v_c[1], 7);
      lb     = level_of(v_c[2], 3);
      idx    = {lr, lg, lb[1:0]};
      g_c[0] = grid7(lr);
      g_c[1] = grid7(lg);
      g_c[2] = grid3(lb[1:0]);
    end else begin
      lg     = level_of(v_c[1], 3);
      idx    = {4'b0000, v_c[0][PIX_W-1], lg[1:0], v_c[2][PIX_W-1]};
      g_c[0] = {PIX_W{v_c[0][PIX_W-1]}};
      g_c[1] = grid3(lg[1:0]);
      g_c[2] = {PIX_W{v_c[2][PIX_W-1]}};
    end

    for (int c = 0; c < 3; c++) begin
      err_c[c] = err_of(v_c[c], g_c[c]);
      if (method_r == METHOD_ATK) begin
        sh_r1[c] = atk_share(err_c[c]);
        sh_r2[c] = atk_share(err_c[c]);
        sh_dl[c] = atk_share(err_c[c]);
        sh_dn[c] = atk_share(err_c[c]);
        sh_dr[c] = atk_share(err_c[c]);
      end else begin
        sh_r1[c] = fs_share(err_c[c], FS_RIGHT);
        sh_r2[c] = '0;
        sh_dl[c] = fs_share(err_c[c], FS_DOWN_LEFT);
        sh_dn[c] = fs_share(err_c[c], FS_DOWN);
        sh_dr[c] = fs_share(err_c[c], FS_DOWN_RIGHT);
      end
      fin_data[c]      = add_err(nrow_prev_r[c], sh_dl[c]);
      pend_data_nxt[c] = add_err(nrow_cur_r[c], sh_dn[c]);
    end

    res.idx  = idx;
    res.last = px_last;
  end

  always_comb begin
    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    acc_cur_nxt   = acc_cur_r;
    acc_cur2_nxt  = acc_cur2_r;
    nrow_prev_nxt = nrow_prev_r;
    nrow_cur_nxt  = nrow_cur_r;
    pend_nxt      = 1'b0;
    if (clr) begin
      col_nxt       = '0;
      first_row_nxt = 1'b1;
      acc_cur_nxt   = '0;
      acc_cur2_nxt  = '0;
      nrow_prev_nxt = '0;
      nrow_cur_nxt  = '0;
    end else if (in_fire) begin
      if (px_last) begin
        col_nxt       = '0;
        first_row_nxt = 1'b0;
        acc_cur_nxt   = '0;
        acc_cur2_nxt  = '0;
        nrow_prev_nxt = '0;
        nrow_cur_nxt  = '0;
        pend_nxt      = 1'b1;
      end else begin
        col_nxt = col_r + col_t'(1);
        for (int c = 0; c < 3; c++) begin
          acc_cur_nxt[c]   = add_err(acc_cur2_r[c], sh_r1[c]);
          acc_cur2_nxt[c]  = has_r2 ? sh_r2[c] : '0;
          nrow_prev_nxt[c] = add_err(nrow_cur_r[c], sh_dn[c]);
          nrow_cur_nxt[c]  = sh_dr[c];
        end
      end
    end
  end

  always_comb begin
    wr_norm_en   = in_fire && has_left;
    wr_en        = wr_norm_en || pend_r;
    wr_addr      = wr_norm_en ? col_t'(col_r - col_t'(1)) : pend_addr_r;
    wr_data      = wr_norm_en ? fin_data : pend_data_r;
    fwd_hit_nxt  = 1'b0;
    fwd_data_nxt = wr_data;
    if (pend_nxt && col_nxt == col_r) begin
      fwd_hit_nxt  = 1'b1;
      fwd_data_nxt = pend_data_nxt;
    end else if (wr_en && col_nxt == wr_addr) begin
      fwd_hit_nxt  = 1'b1;
    end
  end

  edd_ram #(
    .WIDTH(TRIO_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(col_nxt),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_nxt       = res;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r     <= METHOD_FS;
      format_r     <= FMT_RGB121;
      lastcol_r    <= last_col_of(RESET_ROW_WIDTH);
      col_r        <= '0;
      first_row_r  <= 1'b1;
      acc_cur_r    <= '0;
      acc_cur2_r   <= '0;
      nrow_prev_r  <= '0;
      nrow_cur_r   <= '0;
      pend_r       <= 1'b0;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      method_r     <= method_nxt;
      format_r     <= format_nxt;
      lastcol_r    <= lastcol_nxt;
      col_r        <= col_nxt;
      first_row_r  <= first_row_nxt;
      acc_cur_r    <= acc_cur_nxt;
      acc_cur2_r   <= acc_cur2_nxt;
      nrow_prev_r  <= nrow_prev_nxt;
      nrow_cur_r   <= nrow_cur_nxt;
      pend_r       <= pend_nxt;
      fwd_hit_r    <= fwd_hit_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    pend_addr_r <= col_r;
    pend_data_r <= pend_data_nxt;
    fwd_data_r  <= fwd_data_nxt;
    out_r       <= out_nxt;
    skid_r      <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.idx;
  assign out_tlast  = out_r.last;

  ap_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= lastcol_r)
    else $error("column beyond the configured row width");

  ap_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  ap_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && wr_norm_en))
    else $error("row store write port claimed twice");

  ap_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && px_last && !clr) |=> (col_r == '0 && !first_row_r))
    else $error("row end did not restart the column");

  ap_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
